// ===== hdl/cau_pkg.sv =====
// cau_pkg: shared codes, defaults and control struct of the complex arithmetic unit
// used by cau_front, cau_back and complex_arithmetic_unit_core; no dependencies
`default_nettype none

package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int KIND_W         = 3;
	localparam int FLAG_W         = 4;

	localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NEG = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CMP = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              is_equal;
		logic              a_nonzero;
		logic              div_by_zero;
	} cau_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/cau_front.sv =====
// cau_front: takes input transfers, classifies them and holds them in a two-entry queue
// depends on cau_pkg
`default_nettype none

module cau_front #(
	parameter int W = 16,
	parameter int IN_DW = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IN_DW-1:0]           s_tdata,
	input  logic [cau_pkg::KIND_W-1:0] s_tuser,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cau_pkg::cau_ctrl_t         out_ctrl,
	output logic signed [W-1:0]        out_ar,
	output logic signed [W-1:0]        out_ai,
	output logic signed [W-1:0]        out_br,
	output logic signed [W-1:0]        out_bi
);
	import cau_pkg::*;

	localparam int EW = 4 * W;

	cau_ctrl_t        ctrl_q [2];
	logic [EW-1:0]    opnd_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;
	cau_ctrl_t        ctrl_in;
	logic [W-1:0]     ar_in, ai_in, br_in, bi_in;
	logic [EW-1:0]    rd_opnd;

	assign ar_in = s_tdata[W-1:0];
	assign ai_in = s_tdata[2*W-1:W];
	assign br_in = s_tdata[3*W-1:2*W];
	assign bi_in = s_tdata[4*W-1:3*W];

	// classify on entry
	always_comb begin
		ctrl_in.kind        = s_tuser;
		ctrl_in.is_equal    = (ar_in == br_in) && (ai_in == bi_in);
		ctrl_in.a_nonzero   = (ar_in != '0) || (ai_in != '0);
		ctrl_in.div_by_zero = (s_tuser == KIND_DIV) && (br_in == '0) && (bi_in == '0);
	end

	assign s_tready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = s_tvalid && s_tready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_ptr_q] <= ctrl_in;
			opnd_q[wr_ptr_q] <= s_tdata[EW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	assign out_ctrl = ctrl_q[rd_ptr_q];
	assign rd_opnd  = opnd_q[rd_ptr_q];
	assign out_ar   = rd_opnd[W-1:0];
	assign out_ai   = rd_opnd[2*W-1:W];
	assign out_br   = rd_opnd[3*W-1:2*W];
	assign out_bi   = rd_opnd[4*W-1:3*W];

endmodule

`default_nettype wire

// ===== hdl/cau_div.sv =====
// cau_div: pipelined restoring divider, one quotient bit per stage, overflow flagged in the top quotient bit
// no package dependencies; instantiated by cau_back
`default_nettype none

module cau_div #(
	parameter int W = 16,
	parameter int F = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [2*W:0]   num,
	input  logic [2*W-1:0]        den,
	output logic                  neg,
	output logic [W+1:0]          quo
);
	localparam int SW = 2 * W + 1;
	localparam int CW = 3 * W + F + 2;
	localparam int D  = W + 2;

	logic [CW-1:0]   rem_q [D];
	logic [2*W-1:0]  den_q [D];
	logic            neg_q [D];
	logic [W+1:0]    quo_q [D];

	logic [SW-1:0]   mag0;
	logic [CW-1:0]   n0;
	logic            ovf0;

	// first stage: magnitude, scaled numerator, overflow check
	always_comb begin
		mag0 = num[SW-1] ? SW'(-num) : SW'(num);
		n0   = CW'(mag0) << F;
		ovf0 = n0 >= (CW'(den) << (W + 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= n0;
			den_q[0] <= den;
			neg_q[0] <= num[SW-1];
			quo_q[0] <= {ovf0, {(W + 1){1'b0}}};
		end
	end

	for (genvar j = 1; j < D; j++) begin : g_stage
		logic [CW-1:0] dsh;
		logic          ge;
		assign dsh = CW'(den_q[j-1]) << (D - 1 - j);
		assign ge  = rem_q[j-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? rem_q[j-1] - dsh : rem_q[j-1];
				den_q[j] <= den_q[j-1];
				neg_q[j] <= neg_q[j-1];
				quo_q[j] <= quo_q[j-1] | ((W + 2)'(ge) << (D - 1 - j));
			end
		end
	end

	assign neg = neg_q[D-1];
	assign quo = quo_q[D-1];

endmodule

`default_nettype wire

// ===== hdl/cau_back.sv =====
// cau_back: product, sum and divider pipeline with output register
// depends on cau_pkg and cau_div
`default_nettype none

module cau_back #(
	parameter int W = 16,
	parameter int F = 8,
	parameter int OUT_DW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  cau_pkg::cau_ctrl_t         in_ctrl,
	input  logic signed [W-1:0]        in_ar,
	input  logic signed [W-1:0]        in_ai,
	input  logic signed [W-1:0]        in_br,
	input  logic signed [W-1:0]        in_bi,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_DW-1:0]          m_tdata,
	output logic [cau_pkg::FLAG_W-1:0] m_tuser
);
	import cau_pkg::*;

	localparam int SW = 2 * W + 1;
	localparam int MW = 2 * W + 2;
	localparam int D  = W + 2;
	localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

	// clip a sign and magnitude to the signed range: {sat, value}
	function automatic logic [W:0] clip_fn(input logic ng, input logic [MW-1:0] mag);
		logic [MW-1:0] lim;
		logic          s;
		logic [W-1:0]  v;
		begin
			lim = ng ? HALF : HALF - MW'(1);
			s   = mag > lim;
			v   = s ? lim[W-1:0] : mag[W-1:0];
			v   = ng ? W'(-v) : v;
			return {s, v};
		end
	endfunction

	function automatic logic [W:0] clip_s(input logic signed [MW-1:0] x);
		return clip_fn(x[MW-1], x[MW-1] ? MW'(-x) : MW'(x));
	endfunction

	function automatic logic [W:0] scale_s(input logic signed [MW-1:0] x);
		logic [MW-1:0] m;
		begin
			m = x[MW-1] ? MW'(-x) : MW'(x);
			return clip_fn(x[MW-1], m >> F);
		end
	endfunction

	logic en;
	logic out_vld_q;

	assign en       = !out_vld_q || m_tready;
	assign in_ready = en;

	// stage 1: products
	logic                   vld_s1;
	cau_ctrl_t              ctrl_s1;
	logic signed [W-1:0]    ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [2*W-1:0]  p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_s1, p_cc_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= in_ctrl;
			ar_s1   <= in_ar;
			ai_s1   <= in_ai;
			br_s1   <= in_br;
			bi_s1   <= in_bi;
			p_rr_s1 <= in_ar * in_br;
			p_ii_s1 <= in_ai * in_bi;
			p_ir_s1 <= in_ai * in_br;
			p_ri_s1 <= in_ar * in_bi;
			p_bb_s1 <= in_br * in_br;
			p_cc_s1 <= in_bi * in_bi;
		end
	end

	// stage 2: sums, direct results, divider operands
	logic signed [MW-1:0] x_re, x_im;
	logic [W:0]           c_re, c_im;
	logic                 vld_s2;
	cau_ctrl_t            ctrl_s2;
	logic [W-1:0]         re_s2, im_s2;
	logic                 sat_s2;
	logic signed [SW-1:0] num_re_s2, num_im_s2;
	logic [2*W-1:0]       den_s2;

	always_comb begin
		x_re = '0;
		x_im = '0;
		c_re = '0;
		c_im = '0;
		unique case (ctrl_s1.kind)
			KIND_ADD: begin
				c_re = clip_s(MW'(ar_s1) + MW'(br_s1));
				c_im = clip_s(MW'(ai_s1) + MW'(bi_s1));
			end
			KIND_SUB: begin
				c_re = clip_s(MW'(ar_s1) - MW'(br_s1));
				c_im = clip_s(MW'(ai_s1) - MW'(bi_s1));
			end
			KIND_MUL: begin
				x_re = MW'(p_rr_s1) - MW'(p_ii_s1);
				x_im = MW'(p_ir_s1) + MW'(p_ri_s1);
				c_re = scale_s(x_re);
				c_im = scale_s(x_im);
			end
			KIND_NEG: begin
				c_re = clip_s(-MW'(ar_s1));
				c_im = clip_s(-MW'(ai_s1));
			end
			default: begin
				c_re = '0;
				c_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s2   <= ctrl_s1;
			re_s2     <= c_re[W-1:0];
			im_s2     <= c_im[W-1:0];
			sat_s2    <= c_re[W] | c_im[W];
			num_re_s2 <= SW'(p_rr_s1) + SW'(p_ii_s1);
			num_im_s2 <= SW'(p_ir_s1) - SW'(p_ri_s1);
			den_s2    <= $unsigned(p_bb_s1) + $unsigned(p_cc_s1);
		end
	end

	// divider lanes and side delay line
	logic         dneg_re, dneg_im;
	logic [W+1:0] dq_re, dq_im;

	cau_div #(.W(W), .F(F)) u_div_re (
		.clk(clk), .en(en), .num(num_re_s2), .den(den_s2), .neg(dneg_re), .quo(dq_re)
	);
	cau_div #(.W(W), .F(F)) u_div_im (
		.clk(clk), .en(en), .num(num_im_s2), .den(den_s2), .neg(dneg_im), .quo(dq_im)
	);

	cau_ctrl_t    ctrl_d_q [D];
	logic [W-1:0] re_d_q   [D];
	logic [W-1:0] im_d_q   [D];
	logic         sat_d_q  [D];
	logic [D-1:0] vld_d_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_d_q[0] <= ctrl_s2;
			re_d_q[0]   <= re_s2;
			im_d_q[0]   <= im_s2;
			sat_d_q[0]  <= sat_s2;
			for (int i = 1; i < D; i++) begin
				ctrl_d_q[i] <= ctrl_d_q[i-1];
				re_d_q[i]   <= re_d_q[i-1];
				im_d_q[i]   <= im_d_q[i-1];
				sat_d_q[i]  <= sat_d_q[i-1];
			end
		end
	end

	// final select into output register
	logic [W:0]   q_re, q_im;
	cau_ctrl_t    ctrl_f;
	logic [W-1:0] f_re, f_im;
	logic         f_sat;

	always_comb begin
		ctrl_f = ctrl_d_q[D-1];
		q_re   = clip_fn(dneg_re, MW'(dq_re));
		q_im   = clip_fn(dneg_im, MW'(dq_im));
		if (ctrl_f.kind == KIND_DIV) begin
			f_re  = ctrl_f.div_by_zero ? '0 : q_re[W-1:0];
			f_im  = ctrl_f.div_by_zero ? '0 : q_im[W-1:0];
			f_sat = !ctrl_f.div_by_zero && (q_re[W] || q_im[W]);
		end else begin
			f_re  = re_d_q[D-1];
			f_im  = im_d_q[D-1];
			f_sat = sat_d_q[D-1];
		end
	end

	logic [W-1:0] out_re_q, out_im_q;
	logic [FLAG_W-1:0] out_flag_q;

	always_ff @(posedge clk) begin
		if (en) begin
			out_re_q   <= f_re;
			out_im_q   <= f_im;
			out_flag_q <= {f_sat, ctrl_f.div_by_zero, ctrl_f.a_nonzero, ctrl_f.is_equal};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_d_q   <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_d_q   <= {vld_d_q[D-2:0], vld_s2};
			out_vld_q <= vld_d_q[D-1];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DW'({out_im_q, out_re_q});
	assign m_tuser  = out_flag_q;

endmodule

`default_nettype wire

// ===== hdl/complex_arithmetic_unit_core.sv =====
// complex_arithmetic_unit_core: top level of the complex fixed-point arithmetic unit
// depends on cau_pkg, cau_front, cau_back (and cau_div below it)
`default_nettype none

// Complex arithmetic on signed fixed-point operands (DATA_WIDTH bits, FRAC_BITS fraction
// bits, Q8.8 by default): add, subtract, multiply, divide, negate a, or equality compare,
// chosen per transfer by s_tuser. Results are saturated to the signed range; products
// and quotients truncate toward zero. A divide by zero gives zero with div_by_zero set.
// Undefined kinds and compare give a zero result; is_equal and a_nonzero are always
// valid. Throughput is one transfer per clock for as long as m_tready stays high.
// Results pass a product stage and a sum stage, then the divider, which resolves one
// quotient bit per pipeline stage (DATA_WIDTH + 2 stages), then the output register.
// A two-entry queue sits between the input side and the arithmetic pipeline, so
// s_tready stays high while a result waits on m_tready until that queue fills. Every
// kind runs through the same pipeline, so results come out in input order.

module complex_arithmetic_unit_core #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
	parameter int IN_DW      = ((4 * DATA_WIDTH + 7) / 8) * 8,
	parameter int OUT_DW     = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input transfer
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IN_DW-1:0]           s_tdata,  // a_re, a_im, b_re, b_im, zero pad
	input  logic [cau_pkg::KIND_W-1:0] s_tuser,  // kind
	// result transfer
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_DW-1:0]          m_tdata,  // res_re, res_im, zero pad
	output logic [cau_pkg::FLAG_W-1:0] m_tuser   // is_equal, a_nonzero, div_by_zero, saturated
);
	import cau_pkg::*;

	// queue head toward the arithmetic pipeline
	logic                          q_valid;
	logic                          q_ready;
	cau_ctrl_t                     q_ctrl;
	logic signed [DATA_WIDTH-1:0]  q_ar, q_ai, q_br, q_bi;

	// front: classify and queue
	cau_front #(.W(DATA_WIDTH), .IN_DW(IN_DW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_ctrl  (q_ctrl),
		.out_ar    (q_ar),
		.out_ai    (q_ai),
		.out_br    (q_br),
		.out_bi    (q_bi)
	);

	// back: multiply, sum, divide, saturate
	cau_back #(.W(DATA_WIDTH), .F(FRAC_BITS), .OUT_DW(OUT_DW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_ctrl  (q_ctrl),
		.in_ar    (q_ar),
		.in_ai    (q_ai),
		.in_br    (q_br),
		.in_bi    (q_bi),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// a divide by zero always shows a zero result and no saturation
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tdata[2*DATA_WIDTH-1:0] == '0) && !m_tuser[3])
		else $error("divide by zero result not zero");

	// the queue only fills when the result side stalled the cycle before
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// a zero a that equals b and is flagged as a divide by zero gives a zero real result
	a_eq_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] && m_tuser[0] && m_tuser[2] |-> m_tdata[DATA_WIDTH-1:0] == '0)
		else $error("flag combination inconsistent");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench of complex_arithmetic_unit_core
// depends on cau_pkg and complex_arithmetic_unit_core; predicts results per transfer
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import cau_pkg::*;

	localparam int DW = 16;
	localparam int FB = 8;
	localparam int LATENCY = DW + 6;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          eq;
		logic          nz;
		logic          dz;
		logic          sat;
	} cplx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [FLAG_W-1:0] m_tuser;

	cplx_result_t pending_results[$];
	int errors = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	complex_arithmetic_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// saturate an exact value to the signed data range
	function automatic logic [DW-1:0] clamp(input longint v, inout logic sat);
		if (v > 32767) begin
			sat = 1'b1;
			return 16'h7fff;
		end
		if (v < -32768) begin
			sat = 1'b1;
			return 16'h8000;
		end
		return v[DW-1:0];
	endfunction

	// product scaled down by 2^FB, truncated toward zero
	function automatic logic [DW-1:0] scale_prod(input longint v, inout logic sat);
		longint m;
		m = (v < 0 ? -v : v) >>> FB;
		return clamp(v < 0 ? -m : m, sat);
	endfunction

	// num * 2^FB / den, truncated toward zero; the integer part is capped first
	function automatic logic [DW-1:0] scale_quot(input longint num, input longint den,
			inout logic sat);
		longint m, q;
		m = num < 0 ? -num : num;
		q = m / den;
		if (q > 65536)
			q = 65536;
		q = (q << FB) | (((m % den) << FB) / den);
		return clamp(num < 0 ? -q : q, sat);
	endfunction

	function automatic cplx_result_t complex_op(input logic [KIND_W-1:0] kind,
			input logic signed [DW-1:0] ar, ai, br, bi);
		cplx_result_t r;
		longint den;
		logic sat;
		r = '0;
		sat = 1'b0;
		case (kind)
			KIND_ADD: begin
				r.re = clamp(longint'(ar) + br, sat);
				r.im = clamp(longint'(ai) + bi, sat);
			end
			KIND_SUB: begin
				r.re = clamp(longint'(ar) - br, sat);
				r.im = clamp(longint'(ai) - bi, sat);
			end
			KIND_MUL: begin
				r.re = scale_prod(longint'(ar) * br - longint'(ai) * bi, sat);
				r.im = scale_prod(longint'(ai) * br + longint'(ar) * bi, sat);
			end
			KIND_DIV: begin
				if (br == 0 && bi == 0) begin
					r.dz = 1'b1;
				end else begin
					den = longint'(br) * br + longint'(bi) * bi;
					r.re = scale_quot(longint'(ar) * br + longint'(ai) * bi, den, sat);
					r.im = scale_quot(longint'(br) * ai - longint'(ar) * bi, den, sat);
				end
			end
			KIND_NEG: begin
				r.re = clamp(-longint'(ar), sat);
				r.im = clamp(-longint'(ai), sat);
			end
			default: ;
		endcase
		r.sat = sat;
		r.eq = (ar == br) && (ai == bi);
		r.nz = (ar != 0) || (ai != 0);
		return r;
	endfunction

	// one input transfer; the source gap is drawn before raising tvalid
	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DW-1:0] ar, ai,
			br, bi);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {bi, br, ai, ar};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(complex_op(kind, ar, ai, br, bi));
		@(negedge clk);
	endtask

	// operand biased toward corner values
	function automatic logic [DW-1:0] rand_operand();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [KIND_W-1:0] k;
		for (int i = 0; i <= 7; i++) begin
			k = KIND_W'(i);
			send_op(k, 16'h0100, 16'hff00, 16'h0200, 16'h0080);
			send_op(k, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		end
		send_op(KIND_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);   // divide by zero
		send_op(KIND_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);   // quotient overflow
		send_op(KIND_NEG, 16'h8000, 16'h8000, 16'h0000, 16'h0000);   // negate most negative
		send_op(KIND_CMP, 16'h0042, 16'hffbe, 16'h0042, 16'hffbe);   // equal operands
		send_op(KIND_CMP, 16'h0000, 16'h0000, 16'h0000, 16'h0001);   // a zero
		send_op(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_op(KIND_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0001);
		send_op(KIND_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
	endtask

	task automatic test_random(input int count);
		logic [DW-1:0] ar, ai;
		for (int i = 0; i < count; i++) begin
			ar = rand_operand();
			ai = rand_operand();
			if ($urandom_range(7) == 0)
				send_op(KIND_W'($urandom_range(7)), ar, ai, ar, ai);
			else
				send_op(KIND_W'($urandom_range(7)), ar, ai, rand_operand(), rand_operand());
		end
	endtask

	// receiver stall, drawn each falling edge
	always @(negedge clk)
		if (arst_n)
			m_tready <= ($urandom_range(99) >= sink_idle_pct);

	// result checker and watchdog
	always @(posedge clk) begin
		cplx_result_t exp_r;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: tdata=%h tuser=%b", m_tdata, m_tuser);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[15:0] !== exp_r.re) begin
					$error("res_re expected %h actual %h", exp_r.re, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== exp_r.im) begin
					$error("res_im expected %h actual %h", exp_r.im, m_tdata[31:16]);
					errors++;
				end
				if (m_tuser[0] !== exp_r.eq) begin
					$error("is_equal expected %b actual %b", exp_r.eq, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== exp_r.nz) begin
					$error("a_nonzero expected %b actual %b", exp_r.nz, m_tuser[1]);
					errors++;
				end
				if (m_tuser[2] !== exp_r.dz) begin
					$error("div_by_zero expected %b actual %b", exp_r.dz, m_tuser[2]);
					errors++;
				end
				if (m_tuser[3] !== exp_r.sat) begin
					$error("saturated expected %b actual %b", exp_r.sat, m_tuser[3]);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_idle_pct = 18;
		sink_idle_pct = 85;
		test_directed();
		test_random(400);
		src_idle_pct = 85;
		sink_idle_pct = 18;
		test_random(400);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random(430);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
